@@ hdl/sha1_stream_hash_macros.svh @@
// Assertion macros used by the SHA-1 stream hasher checker.
// Each macro expects signals named clk and rst in the scope that uses it.
`ifndef SHA1_STREAM_HASH_MACROS_SVH
`define SHA1_STREAM_HASH_MACROS_SVH

// A signal holds its value while a word waits on a stalled channel.
`define SHA1_HOLD(label, vld, rdy, sig) \
  label: assert property (@(posedge clk) disable iff (rst) \
    ((vld) && !(rdy)) |=> $stable(sig)) else $error("stalled value changed");

// A condition in the same cycle.
`define SHA1_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) \
    (ante) |-> (cons)) else $error("same-cycle check failed");

// A condition in the next cycle.
`define SHA1_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) \
    (ante) |=> (cons)) else $error("next-cycle check failed");

`endif

@@ hdl/sha1_pkg.sv @@
// Shared types, constants and round functions of the SHA-1 stream hasher.
// Used by the front end, the word queue, the compression back end and the top level.
package sha1_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [6:0] LAST_ROUND = 7'd79;
  localparam logic [3:0] LAST_BLOCK_WORD = 4'd15;
  // Index of the word just before the two length words of a final block.
  localparam logic [3:0] PAD_LAST_IDX = 4'd13;
  localparam logic [2:0] LAST_OUT_IDX = 3'd4;
  localparam logic [7:0] MARK_BYTE = 8'h80;

  localparam logic [31:0] INIT_CHAIN [5] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  typedef struct packed {
    logic [31:0] word;
    logic        final_word;
  } q_entry_t;

  typedef enum logic [2:0] {
    FS_INPUT,
    FS_MARK,
    FS_ZERO,
    FS_LEN_HI,
    FS_LEN_LO
  } front_state_t;

  typedef enum logic [1:0] {
    BS_LOAD,
    BS_ROUND,
    BS_ADD,
    BS_OUT
  } back_state_t;

  function automatic logic [31:0] round_f(logic [6:0] rnd, logic [31:0] b,
                                          logic [31:0] c, logic [31:0] d);
    logic [31:0] f;
    priority if (rnd < 7'd20) f = (b & c) | (~b & d);
    else if (rnd < 7'd40) f = b ^ c ^ d;
    else if (rnd < 7'd60) f = (b & c) | (b & d) | (c & d);
    else f = b ^ c ^ d;
    return f;
  endfunction

  function automatic logic [31:0] round_k(logic [6:0] rnd);
    logic [31:0] k;
    priority if (rnd < 7'd20) k = K0;
    else if (rnd < 7'd40) k = K1;
    else if (rnd < 7'd60) k = K2;
    else k = K3;
    return k;
  endfunction

endpackage

@@ hdl/sha1_queue.sv @@
// Short first-in first-out queue of block words between front and back end.
// Depends on sha1_pkg for the entry type and depth.
module sha1_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push_valid,
  output logic               push_ready,
  input  sha1_pkg::q_entry_t push_entry,
  output logic               pop_valid,
  input  logic               pop_ready,
  output sha1_pkg::q_entry_t pop_entry
);

  sha1_pkg::q_entry_t             mem [sha1_pkg::QUEUE_DEPTH];
  logic [sha1_pkg::QPTR_W-1:0]    wptr;
  logic [sha1_pkg::QPTR_W-1:0]    rptr;
  logic [sha1_pkg::QCNT_W-1:0]    count;
  logic                           do_push;
  logic                           do_pop;

  assign push_ready = (count != sha1_pkg::QCNT_W'(sha1_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_entry  = mem[rptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) wptr <= wptr + 1'b1;
      if (do_pop) rptr <= rptr + 1'b1;
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wptr] <= push_entry;
  end

endmodule

@@ hdl/sha1_front.sv @@
// Front end: takes message bytes, packs them into words and appends the padding.
// Depends on sha1_pkg; feeds the word queue.
module sha1_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         data_byte,
  input  logic               has_byte,
  input  logic               end_of_message,
  output logic               push_valid,
  input  logic               push_ready,
  output sha1_pkg::q_entry_t push_entry
);

  sha1_pkg::front_state_t state, state_next;
  logic [63:0] bit_count, bit_count_next;
  logic [31:0] acc, acc_next;
  logic [1:0]  pos, pos_next;
  logic [3:0]  word_idx, word_idx_next;
  logic [31:0] mark_word;

  always_comb begin
    unique case (pos)
      2'd0: mark_word = {sha1_pkg::MARK_BYTE, 24'h0};
      2'd1: mark_word = {acc[31:24], sha1_pkg::MARK_BYTE, 16'h0};
      2'd2: mark_word = {acc[31:16], sha1_pkg::MARK_BYTE, 8'h0};
      2'd3: mark_word = {acc[31:8], sha1_pkg::MARK_BYTE};
      default: mark_word = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sha1_pkg::FS_INPUT;
      bit_count <= '0;
      pos       <= '0;
      word_idx  <= '0;
    end else begin
      state     <= state_next;
      bit_count <= bit_count_next;
      pos       <= pos_next;
      word_idx  <= word_idx_next;
    end
  end

  always_ff @(posedge clk) begin
    acc <= acc_next;
  end

  always_comb begin
    state_next     = state;
    bit_count_next = bit_count;
    acc_next       = acc;
    pos_next       = pos;
    word_idx_next  = word_idx;
    in_ready       = 1'b0;
    push_valid     = 1'b0;
    push_entry     = '{word: '0, final_word: 1'b0};
    unique case (state)
      sha1_pkg::FS_INPUT: begin
        in_ready = push_ready;
        if (in_valid && push_ready) begin
          if (has_byte) begin
            bit_count_next = bit_count + 64'd8;
            pos_next = pos + 1'b1;
            unique case (pos)
              2'd0: acc_next[31:24] = data_byte;
              2'd1: acc_next[23:16] = data_byte;
              2'd2: acc_next[15:8] = data_byte;
              2'd3: begin
                push_valid = 1'b1;
                push_entry = '{word: {acc[31:8], data_byte}, final_word: 1'b0};
                word_idx_next = word_idx + 1'b1;
              end
              default: acc_next = acc;
            endcase
          end
          if (end_of_message) state_next = sha1_pkg::FS_MARK;
        end
      end
      sha1_pkg::FS_MARK: begin
        push_valid = 1'b1;
        push_entry = '{word: mark_word, final_word: 1'b0};
        if (push_ready) begin
          pos_next = '0;
          word_idx_next = word_idx + 1'b1;
          state_next = (word_idx == sha1_pkg::PAD_LAST_IDX) ? sha1_pkg::FS_LEN_HI
                                                              : sha1_pkg::FS_ZERO;
        end
      end
      sha1_pkg::FS_ZERO: begin
        push_valid = 1'b1;
        if (push_ready) begin
          word_idx_next = word_idx + 1'b1;
          if (word_idx == sha1_pkg::PAD_LAST_IDX) state_next = sha1_pkg::FS_LEN_HI;
        end
      end
      sha1_pkg::FS_LEN_HI: begin
        push_valid = 1'b1;
        push_entry = '{word: bit_count[63:32], final_word: 1'b0};
        if (push_ready) begin
          word_idx_next = word_idx + 1'b1;
          state_next = sha1_pkg::FS_LEN_LO;
        end
      end
      sha1_pkg::FS_LEN_LO: begin
        push_valid = 1'b1;
        push_entry = '{word: bit_count[31:0], final_word: 1'b1};
        if (push_ready) begin
          word_idx_next = '0;
          bit_count_next = '0;
          state_next = sha1_pkg::FS_INPUT;
        end
      end
      default: state_next = sha1_pkg::FS_INPUT;
    endcase
  end

endmodule

@@ hdl/sha1_back.sv @@
// Back end: gathers sixteen block words, runs the 80 rounds and emits the digest.
// Depends on sha1_pkg; drains the word queue.
module sha1_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  output logic               q_ready,
  input  sha1_pkg::q_entry_t q_entry,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        digest_word,
  output logic [2:0]         word_index,
  output logic               last_word
);

  sha1_pkg::back_state_t state, state_next;
  logic [3:0]  load_cnt, load_cnt_next;
  logic [6:0]  round, round_next;
  logic [2:0]  out_idx, out_idx_next;
  logic        final_blk, final_blk_next;
  logic [31:0] chain [5];
  logic [31:0] work [5];
  logic [31:0] sched [16];
  logic        load_word, start_rounds, round_step, do_add, chain_reset;
  logic [31:0] w_cur;
  logic [31:0] tmp;

  always_comb begin
    if (round < 7'd16) begin
      w_cur = sched[0];
    end else begin
      w_cur = sched[13] ^ sched[8] ^ sched[2] ^ sched[0];
      w_cur = {w_cur[30:0], w_cur[31]};
    end
    tmp = {work[0][26:0], work[0][31:27]}
        + sha1_pkg::round_f(round, work[1], work[2], work[3])
        + work[4] + sha1_pkg::round_k(round) + w_cur;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sha1_pkg::BS_LOAD;
      load_cnt  <= '0;
      round     <= '0;
      out_idx   <= '0;
      final_blk <= 1'b0;
    end else begin
      state     <= state_next;
      load_cnt  <= load_cnt_next;
      round     <= round_next;
      out_idx   <= out_idx_next;
      final_blk <= final_blk_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || chain_reset) begin
      for (int i = 0; i < 5; i++) chain[i] <= sha1_pkg::INIT_CHAIN[i];
    end else if (do_add) begin
      for (int i = 0; i < 5; i++) chain[i] <= chain[i] + work[i];
    end
  end

  always_ff @(posedge clk) begin
    if (load_word || round_step) begin
      for (int i = 0; i < 15; i++) sched[i] <= sched[i + 1];
      sched[15] <= load_word ? q_entry.word : w_cur;
    end
    if (start_rounds) begin
      for (int i = 0; i < 5; i++) work[i] <= chain[i];
    end else if (round_step) begin
      work[0] <= tmp;
      work[1] <= work[0];
      work[2] <= {work[1][1:0], work[1][31:2]};
      work[3] <= work[2];
      work[4] <= work[3];
    end
  end

  always_comb begin
    state_next     = state;
    load_cnt_next  = load_cnt;
    round_next     = round;
    out_idx_next   = out_idx;
    final_blk_next = final_blk;
    q_ready        = 1'b0;
    out_valid      = 1'b0;
    load_word      = 1'b0;
    start_rounds   = 1'b0;
    round_step     = 1'b0;
    do_add         = 1'b0;
    chain_reset    = 1'b0;
    unique case (state)
      sha1_pkg::BS_LOAD: begin
        q_ready = 1'b1;
        if (q_valid) begin
          load_word = 1'b1;
          load_cnt_next = load_cnt + 1'b1;
          if (load_cnt == sha1_pkg::LAST_BLOCK_WORD) begin
            start_rounds = 1'b1;
            final_blk_next = q_entry.final_word;
            round_next = '0;
            state_next = sha1_pkg::BS_ROUND;
          end
        end
      end
      sha1_pkg::BS_ROUND: begin
        round_step = 1'b1;
        round_next = round + 1'b1;
        if (round == sha1_pkg::LAST_ROUND) state_next = sha1_pkg::BS_ADD;
      end
      sha1_pkg::BS_ADD: begin
        do_add = 1'b1;
        state_next = final_blk ? sha1_pkg::BS_OUT : sha1_pkg::BS_LOAD;
      end
      sha1_pkg::BS_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          out_idx_next = out_idx + 1'b1;
          if (out_idx == sha1_pkg::LAST_OUT_IDX) begin
            out_idx_next = '0;
            chain_reset = 1'b1;
            state_next = sha1_pkg::BS_LOAD;
          end
        end
      end
      default: state_next = sha1_pkg::BS_LOAD;
    endcase
  end

  assign digest_word = chain[out_idx];
  assign word_index  = out_idx;
  assign last_word   = (out_idx == sha1_pkg::LAST_OUT_IDX);

endmodule

@@ hdl/sha1_stream_hash.sv @@
// Top level of the SHA-1 stream hasher: front end, word queue and back end.
// Depends on sha1_pkg, sha1_front, sha1_queue and sha1_back.
//
//   channel | handshake           | payload
//   --------+---------------------+-----------------------------------------
//   in      | in_valid, in_ready  | data_byte, has_byte, end_of_message
//   out     | out_valid, out_ready| digest_word, word_index, last_word
//
// The front end takes one byte per cycle while the four-entry queue has room.
// While the back end runs the 80 rounds and the add step of a block, only 16
// bytes fit in the queue; the other 48 bytes then arrive one per cycle.
// A message ends in one or two padded blocks, then the five digest words go out.
// The next message can enter while the back end still works on the last one.
// Reset returns both ends to their idle state and the chaining words to the
// initial values; no clearing pass is needed.
module sha1_stream_hash (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        has_byte,
  input  logic        end_of_message,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);

  logic               push_valid;
  logic               push_ready;
  sha1_pkg::q_entry_t push_entry;
  logic               pop_valid;
  logic               pop_ready;
  sha1_pkg::q_entry_t pop_entry;

  sha1_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .data_byte      (data_byte),
    .has_byte       (has_byte),
    .end_of_message (end_of_message),
    .push_valid     (push_valid),
    .push_ready     (push_ready),
    .push_entry     (push_entry)
  );

  sha1_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry)
  );

  sha1_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (pop_valid),
    .q_ready     (pop_ready),
    .q_entry     (pop_entry),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .digest_word (digest_word),
    .word_index  (word_index),
    .last_word   (last_word)
  );

endmodule

@@ hdl/sha1_checker.sv @@
// Port-level checks on the digest output of the SHA-1 stream hasher.
// Depends on sha1_stream_hash_macros.svh; bound to sha1_stream_hash below.
`include "sha1_stream_hash_macros.svh"

module sha1_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] digest_word,
  input logic [2:0]  word_index,
  input logic        last_word
);

  `SHA1_HOLD(a_out_valid_holds, out_valid, out_ready, out_valid)
  `SHA1_HOLD(a_out_word_holds, out_valid, out_ready, digest_word)
  `SHA1_IMPLY(a_index_range, out_valid, word_index <= 3'd4)
  `SHA1_IMPLY(a_last_on_fifth, out_valid, last_word == (word_index == 3'd4))
  `SHA1_NEXT(a_words_in_order, out_valid && out_ready && !last_word, out_valid && (word_index == $past(word_index) + 3'd1))

endmodule

bind sha1_stream_hash sha1_checker u_sha1_checker (.*);
